FILE: rtl/lob_pkg.sv
// Package for the limit order book matcher: order and report types, the
// price-time priority compare, report kind codes and cell operation codes.
// No dependencies.
`default_nettype none
package lob_pkg;

    // One resting order as held in a book slot.
    typedef struct packed {
        logic [31:0]        price;
        logic signed [31:0] qty;
        logic [31:0]        ts;
        logic [31:0]        id;
    } t_order;

    // One report as it leaves the block.
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         sec;
        logic               side;
        logic               ok;
        logic [31:0]        id;
        logic [31:0]        price;
        logic signed [31:0] qty;
        logic [31:0]        ts;
        logic [31:0]        matched;
    } t_result;

    // Input function codes.
    localparam logic [1:0] F_SETPRICE = 2'd0;
    localparam logic [1:0] F_NEW      = 2'd1;
    localparam logic [1:0] F_CANCEL   = 2'd2;
    localparam logic [1:0] F_NONE     = 2'd3;

    // Report kinds.
    localparam logic [2:0] K_ECHO   = 3'd0;
    localparam logic [2:0] K_TRADE  = 3'd1;
    localparam logic [2:0] K_MPRICE = 3'd2;
    localparam logic [2:0] K_EXEC   = 3'd3;
    localparam logic [2:0] K_CANCEL = 3'd4;
    localparam logic [2:0] K_REJECT = 3'd5;

    // Operations broadcast to the row of cells.
    localparam logic [2:0] OP_HOLD  = 3'd0;
    localparam logic [2:0] OP_SHIFT = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_UP    = 3'd3;
    localparam logic [2:0] OP_DOWN  = 3'd4;

    // Command to the cells: operation and the side of the loaded book.
    typedef struct packed {
        logic [2:0] op;
        logic       side;
    } t_cell_cmd;

    // Status of one cell in a sift step.
    typedef struct packed {
        logic up;
        logic sel_l;
        logic sel_r;
    } t_cell_stat;

    // Status of the whole row.
    typedef struct packed {
        logic up;
        logic sel_l;
        logic sel_r;
        logic hit;
    } t_row_stat;

    // Order a ranks ahead of order b on the given side (0 buy, 1 sell).
    function automatic logic better(input logic side, input t_order a, input t_order b);
        logic res;
        if (a.price == b.price) begin
            res = (a.ts < b.ts);
        end else if (side) begin
            res = (a.price < b.price);
        end else begin
            res = (a.price > b.price);
        end
        return res;
    endfunction

    // Builds one report.
    function automatic t_result mk_res(input logic [2:0] kind, input logic [7:0] sec,
                                       input logic side, input logic ok,
                                       input logic [31:0] id, input logic [31:0] price,
                                       input logic signed [31:0] qty,
                                       input logic [31:0] ts, input logic [31:0] matched);
        t_result r;
        r.kind    = kind;
        r.sec     = sec;
        r.side    = side;
        r.ok      = ok;
        r.id      = id;
        r.price   = price;
        r.qty     = qty;
        r.ts      = ts;
        r.matched = matched;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lob_cell.sv
// One heap slot of the working book: holds an order, shifts along the chain,
// and takes part in sift steps with its fixed parent and children.
// Depends on lob_pkg.
`default_nettype none
module lob_cell
    import lob_pkg::*;
#(
    parameter int ORDERS_PER_SIDE = 16,
    parameter int IDX             = 0
) (
    input  wire logic                                   i_clk,
    input  wire t_cell_cmd                              i_cmd,
    input  wire logic [$clog2(ORDERS_PER_SIDE)-1:0]     i_idx,
    input  wire logic [$clog2(ORDERS_PER_SIDE+1)-1:0]   i_cnt,
    input  wire t_order                                 i_wdata,
    input  wire t_order                                 i_next,
    input  wire t_order                                 i_parent,
    input  wire t_order                                 i_left,
    input  wire t_order                                 i_right,
    input  wire t_cell_stat                             i_par_stat,
    input  wire t_cell_stat                             i_lc_stat,
    input  wire t_cell_stat                             i_rc_stat,
    input  wire logic [31:0]                            i_cid,
    output t_order                                      o_val,
    output t_cell_stat                                  o_stat,
    output logic                                        o_hit
);

    localparam int  SW      = $clog2(ORDERS_PER_SIDE);
    localparam int  LI      = 2 * IDX + 1;
    localparam int  RI      = 2 * IDX + 2;
    localparam bit  IS_LEFT = (IDX % 2) == 1;

    t_order r_val;
    t_order n_val;
    logic   active;
    logic   up;
    logic   take_l;
    logic   take_r;
    logic   par_pick;
    t_order best;

    // Local decisions of a sift step at the active slot.
    always_comb begin
        active   = (i_idx == SW'(IDX));
        up       = active && (IDX > 0) && better(i_cmd.side, r_val, i_parent);
        take_l   = (int'(i_cnt) > LI) && better(i_cmd.side, i_left, r_val);
        best     = take_l ? i_left : r_val;
        take_r   = (int'(i_cnt) > RI) && better(i_cmd.side, i_right, best);
        par_pick = (IDX > 0) && (IS_LEFT ? i_par_stat.sel_l : i_par_stat.sel_r);
        o_stat.up    = up;
        o_stat.sel_r = active && take_r;
        o_stat.sel_l = active && take_l && !take_r;
        o_hit        = (int'(i_cnt) > IDX) && (r_val.id == i_cid);
    end

    // Next slot contents for each operation.
    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            OP_SHIFT: n_val = i_next;
            OP_WRITE: begin
                if (active) begin
                    n_val = i_wdata;
                end
            end
            OP_UP: begin
                if (up) begin
                    n_val = i_parent;
                end else if (i_lc_stat.up) begin
                    n_val = i_left;
                end else if (i_rc_stat.up) begin
                    n_val = i_right;
                end
            end
            OP_DOWN: begin
                if (o_stat.sel_l) begin
                    n_val = i_left;
                end else if (o_stat.sel_r) begin
                    n_val = i_right;
                end else if (par_pick) begin
                    n_val = i_parent;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

FILE: rtl/lob_row.sv
// Row of heap cells holding the book under work, wired as a shift chain and
// as a binary heap; gathers the row status. Depends on lob_pkg and lob_cell.
`default_nettype none
module lob_row
    import lob_pkg::*;
#(
    parameter int ORDERS_PER_SIDE = 16
) (
    input  wire logic                                   i_clk,
    input  wire t_cell_cmd                              i_cmd,
    input  wire logic [$clog2(ORDERS_PER_SIDE)-1:0]     i_idx,
    input  wire logic [$clog2(ORDERS_PER_SIDE+1)-1:0]   i_cnt,
    input  wire t_order                                 i_wdata,
    input  wire t_order                                 i_shin,
    input  wire logic [31:0]                            i_cid,
    input  wire logic [$clog2(ORDERS_PER_SIDE)-1:0]     i_ridx,
    output t_order                                      o_top,
    output t_order                                      o_rdata,
    output t_row_stat                                   o_stat,
    output logic [$clog2(ORDERS_PER_SIDE)-1:0]          o_hit_idx
);

    localparam int N  = ORDERS_PER_SIDE;
    localparam int SW = $clog2(ORDERS_PER_SIDE);

    t_order     w_val  [N];
    t_cell_stat w_stat [N];
    logic [N-1:0] w_hit;

    for (genvar j = 0; j < N; j++) begin : g_cell
        t_order     next_v;
        t_order     par_v;
        t_order     left_v;
        t_order     right_v;
        t_cell_stat par_s;
        t_cell_stat lc_s;
        t_cell_stat rc_s;

        if (j < N - 1) begin : g_next
            assign next_v = w_val[j+1];
        end else begin : g_tail
            assign next_v = i_shin;
        end

        if (j > 0) begin : g_par
            assign par_v = w_val[(j-1)/2];
            assign par_s = w_stat[(j-1)/2];
        end else begin : g_root
            assign par_v = '0;
            assign par_s = '0;
        end

        if (2 * j + 1 < N) begin : g_lc
            assign left_v = w_val[2*j+1];
            assign lc_s   = w_stat[2*j+1];
        end else begin : g_no_lc
            assign left_v = '0;
            assign lc_s   = '0;
        end

        if (2 * j + 2 < N) begin : g_rc
            assign right_v = w_val[2*j+2];
            assign rc_s    = w_stat[2*j+2];
        end else begin : g_no_rc
            assign right_v = '0;
            assign rc_s    = '0;
        end

        lob_cell #(
            .ORDERS_PER_SIDE (ORDERS_PER_SIDE),
            .IDX             (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (i_cmd),
            .i_idx      (i_idx),
            .i_cnt      (i_cnt),
            .i_wdata    (i_wdata),
            .i_next     (next_v),
            .i_parent   (par_v),
            .i_left     (left_v),
            .i_right    (right_v),
            .i_par_stat (par_s),
            .i_lc_stat  (lc_s),
            .i_rc_stat  (rc_s),
            .i_cid      (i_cid),
            .o_val      (w_val[j]),
            .o_stat     (w_stat[j]),
            .o_hit      (w_hit[j])
        );
    end

    // Only the active cell raises a flag, so the row status is an OR.
    always_comb begin
        o_stat    = '0;
        o_hit_idx = '0;
        for (int j = 0; j < N; j++) begin
            o_stat.up    = o_stat.up    | w_stat[j].up;
            o_stat.sel_l = o_stat.sel_l | w_stat[j].sel_l;
            o_stat.sel_r = o_stat.sel_r | w_stat[j].sel_r;
        end
        o_stat.hit = |w_hit;
        // First match in storage order.
        for (int j = N - 1; j >= 0; j--) begin
            if (w_hit[j]) begin
                o_hit_idx = SW'(j);
            end
        end
    end

    assign o_top   = w_val[0];
    assign o_rdata = w_val[i_ridx];

endmodule
`default_nettype wire

FILE: rtl/limit_order_book_matcher.sv
// Top level of the limit order book matcher: sequencer, book and security
// memories, report staging. Depends on lob_pkg and lob_row.
//
//   channel   direction  handshake                 payload
//   ------    ---------  ------------------------  -------------------------------
//   command   in         start high, busy low      i_func .. i_cancel_id
//   report    out        o_valid for one cycle     o_kind .. o_resting_id, o_last
//
// An item first reads the security record, then streams each book it touches
// from the book memory into the cell row and back. A cross that fills the resting
// order removes it from the heap with sift steps; one that leaves it in place
// writes its reduced quantity back at the root. A new order that rests is then
// inserted into its own book with sift steps after its crosses; a set-price
// touches no book. Reports leave through a one-deep staging register; the final
// one leaves as the block goes idle.
// Reset is synchronous and active low and empties every book at once.
`default_nettype none
module limit_order_book_matcher
    import lob_pkg::*;
#(
    parameter int NUM_SECURITIES  = 4,
    parameter int ORDERS_PER_SIDE = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_func,
    input  wire logic [7:0]         i_security,
    input  wire logic               i_side,
    input  wire logic               i_order_kind,
    input  wire logic [31:0]        i_order_id,
    input  wire logic [31:0]        i_price,
    input  wire logic [30:0]        i_quantity,
    input  wire logic [31:0]        i_timestamp,
    input  wire logic [31:0]        i_cancel_id,
    output logic                    busy,
    output logic                    o_valid,
    output logic [2:0]              o_kind,
    output logic [7:0]              o_security_res,
    output logic                    o_side_res,
    output logic                    o_order_kind_res,
    output logic [31:0]             o_order_id_res,
    output logic [31:0]             o_price_res,
    output logic signed [31:0]      o_quantity_res,
    output logic [31:0]             o_timestamp_res,
    output logic [31:0]             o_resting_id,
    output logic                    o_last
);

    localparam int N      = ORDERS_PER_SIDE;
    localparam int SW     = $clog2(ORDERS_PER_SIDE);
    localparam int CW     = $clog2(ORDERS_PER_SIDE + 1);
    localparam int SECW   = (NUM_SECURITIES > 1) ? $clog2(NUM_SECURITIES) : 1;
    localparam int AW     = 1 + SECW + SW;
    localparam int BDEPTH = 2 ** AW;
    localparam int MW     = 2 * CW + 32;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_META   = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_CAN    = 5'd3;
    localparam logic [4:0] S_REM    = 5'd4;
    localparam logic [4:0] S_REMCHK = 5'd5;
    localparam logic [4:0] S_SUP    = 5'd6;
    localparam logic [4:0] S_SDN    = 5'd7;
    localparam logic [4:0] S_CROSS  = 5'd8;
    localparam logic [4:0] S_TRADE  = 5'd9;
    localparam logic [4:0] S_MPR    = 5'd10;
    localparam logic [4:0] S_FILL   = 5'd11;
    localparam logic [4:0] S_AFTREM = 5'd12;
    localparam logic [4:0] S_REMAIN = 5'd13;
    localparam logic [4:0] S_OWN    = 5'd14;
    localparam logic [4:0] S_INS    = 5'd15;
    localparam logic [4:0] S_STORE  = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    // Control state.
    logic [4:0]     r_state, n_state;
    logic [4:0]     r_ret, n_ret;
    logic [4:0]     r_after, n_after;
    logic [CW-1:0]  r_k, n_k;
    logic [CW-1:0]  r_n, n_n;
    logic [SW-1:0]  r_i, n_i;
    logic           r_bside, n_bside;
    logic [NUM_SECURITIES-1:0] r_mvalid;

    // Item and security registers.
    logic [1:0]         r_func;
    logic [7:0]         r_sec;
    logic               r_side;
    logic               r_ok, n_ok;
    logic [31:0]        r_id;
    logic [31:0]        r_price, n_price;
    logic signed [31:0] r_aq, n_aq;
    logic [31:0]        r_ts;
    logic [31:0]        r_cid;
    logic signed [31:0] r_na, n_na;
    logic signed [31:0] r_nm, n_nm;
    logic [CW-1:0]      r_bcnt, n_bcnt;
    logic [CW-1:0]      r_scnt, n_scnt;
    logic [31:0]        r_mp, n_mp;

    // Report staging.
    logic    r_pv;
    t_result r_pend;
    logic    r_ov;
    t_result r_out;
    logic    r_olast;

    // Memories.
    t_order       r_bk_mem [BDEPTH];
    t_order       r_bk_rd;
    logic [MW-1:0] r_meta_mem [NUM_SECURITIES];
    logic [MW-1:0] r_meta_rd;

    // Sequencer outputs.
    t_cell_cmd     c_cmd;
    logic [SW-1:0] c_idx;
    t_order        c_wdata;
    logic [SW-1:0] c_ridx;
    logic [SW-1:0] c_slot;
    logic          bk_we;
    logic          meta_we;
    logic          em_v;
    t_result       em;
    logic          flush;

    // Row results.
    t_order        row_top;
    t_order        row_rdata;
    t_row_stat     row_stat;
    logic [SW-1:0] row_hit_idx;

    // Helpers.
    logic          acc;
    logic          in_range;
    logic          mvalid;
    logic [CW-1:0] m_bcnt;
    logic [CW-1:0] m_scnt;
    logic [31:0]   m_mp;
    logic [CW-1:0] own_cnt;
    logic [CW-1:0] nn;
    logic [SW-1:0] w_par;
    logic [SW:0]   w_lc;
    logic [SW:0]   w_rc;
    logic          cross_ok;
    t_order        top_fill;

    assign acc      = start && !busy;
    assign in_range = ({1'b0, i_security} < 9'(NUM_SECURITIES));
    assign busy     = (r_state != S_IDLE);

    // Security record: entries never written read as their reset value.
    always_comb begin
        mvalid = r_mvalid[r_sec[SECW-1:0]];
        m_bcnt = mvalid ? r_meta_rd[MW-1 -: CW] : '0;
        m_scnt = mvalid ? r_meta_rd[31+CW -: CW] : '0;
        m_mp   = mvalid ? r_meta_rd[31:0] : {24'd0, r_sec};
    end

    always_comb begin
        own_cnt  = r_side ? r_scnt : r_bcnt;
        nn       = r_n - CW'(1);
        w_par    = SW'((r_i - SW'(1)) >> 1);
        w_lc     = {r_i, 1'b1};
        w_rc     = w_lc + (SW+1)'(1);
        cross_ok = (r_n != '0) &&
                   (r_ok || (r_side ? (r_price <= row_top.price)
                                    : (r_price >= row_top.price)));
        top_fill     = row_top;
        top_fill.qty = r_nm;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_after = r_after;
        n_k     = r_k;
        n_n     = r_n;
        n_i     = r_i;
        n_bside = r_bside;
        n_ok    = r_ok;
        n_price = r_price;
        n_aq    = r_aq;
        n_na    = r_na;
        n_nm    = r_nm;
        n_bcnt  = r_bcnt;
        n_scnt  = r_scnt;
        n_mp    = r_mp;
        c_cmd.op   = OP_HOLD;
        c_cmd.side = r_bside;
        c_idx   = r_i;
        c_wdata = row_rdata;
        c_ridx  = nn[SW-1:0];
        c_slot  = r_k[SW-1:0];
        bk_we   = 1'b0;
        meta_we = 1'b0;
        em_v    = 1'b0;
        em      = '0;
        flush   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc && in_range && (i_func != F_NONE)) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                n_bcnt = m_bcnt;
                n_scnt = m_scnt;
                n_mp   = m_mp;
                n_k    = '0;
                case (r_func)
                    F_SETPRICE: begin
                        n_mp    = r_price;
                        em_v    = 1'b1;
                        em      = mk_res(K_MPRICE, r_sec, 1'b0, 1'b0, '0, r_price, '0, '0, '0);
                        n_state = S_DONE;
                    end
                    F_CANCEL: begin
                        em_v    = 1'b1;
                        em      = mk_res(K_CANCEL, r_sec, 1'b0, 1'b0, r_cid, '0, '0, '0, '0);
                        n_bside = 1'b0;
                        n_n     = m_bcnt;
                        n_after = S_CAN;
                        n_state = S_LOAD;
                    end
                    default: begin
                        em_v    = 1'b1;
                        em      = mk_res(K_ECHO, r_sec, r_side, r_ok, r_id, r_price, r_aq,
                                         r_ts, '0);
                        n_bside = !r_side;
                        n_n     = r_side ? m_bcnt : m_scnt;
                        n_after = S_CROSS;
                        n_state = S_LOAD;
                    end
                endcase
            end
            S_LOAD: begin
                if (r_k != '0) begin
                    c_cmd.op = OP_SHIFT;
                end
                if (r_k == CW'(N)) begin
                    n_k     = '0;
                    n_state = r_after;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_CAN: begin
                if (row_stat.hit) begin
                    n_i     = row_hit_idx;
                    n_ret   = S_STORE;
                    n_after = S_DONE;
                    n_state = S_REM;
                end else if (!r_bside) begin
                    n_bside = 1'b1;
                    n_n     = r_scnt;
                    n_after = S_CAN;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REM: begin
                n_n = nn;
                if (CW'(r_i) >= nn) begin
                    n_state = r_ret;
                end else begin
                    c_cmd.op = OP_WRITE;
                    c_wdata  = row_rdata;
                    n_state  = S_REMCHK;
                end
            end
            S_REMCHK: begin
                c_cmd.op = OP_UP;
                if (row_stat.up) begin
                    n_i     = w_par;
                    n_state = S_SUP;
                end else begin
                    n_state = S_SDN;
                end
            end
            S_SUP: begin
                c_cmd.op = OP_UP;
                if (row_stat.up) begin
                    n_i = w_par;
                end else begin
                    n_state = r_ret;
                end
            end
            S_SDN: begin
                c_cmd.op = OP_DOWN;
                if (row_stat.sel_l) begin
                    n_i = w_lc[SW-1:0];
                end else if (row_stat.sel_r) begin
                    n_i = w_rc[SW-1:0];
                end else begin
                    n_state = r_ret;
                end
            end
            S_CROSS: begin
                n_state = cross_ok ? S_TRADE : S_REMAIN;
            end
            S_TRADE: begin
                em_v = 1'b1;
                em   = mk_res(K_TRADE, r_sec, r_side, r_ok, r_id, r_price, r_aq, r_ts,
                              row_top.id);
                n_na = r_aq - row_top.qty;
                n_nm = row_top.qty - r_aq;
                if (r_mp != row_top.price) begin
                    n_mp    = row_top.price;
                    n_state = S_MPR;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_MPR: begin
                em_v    = 1'b1;
                em      = mk_res(K_MPRICE, r_sec, 1'b0, 1'b0, '0, r_mp, '0, '0, '0);
                n_state = S_FILL;
            end
            S_FILL: begin
                n_aq = r_na;
                em_v = 1'b1;
                if (r_nm <= 0) begin
                    em      = mk_res(K_EXEC, r_sec, r_bside, 1'b0, row_top.id, row_top.price,
                                     r_nm, row_top.ts, '0);
                    n_i     = '0;
                    n_ret   = S_AFTREM;
                    n_state = S_REM;
                end else begin
                    // Resting order survives with its reduced quantity.
                    em       = mk_res(K_EXEC, r_sec, r_side, r_ok, r_id, r_price, r_na,
                                      r_ts, '0);
                    c_cmd.op = OP_WRITE;
                    c_idx    = '0;
                    c_wdata  = top_fill;
                    n_after  = S_DONE;
                    n_state  = S_STORE;
                end
            end
            S_AFTREM: begin
                if (r_aq <= 0) begin
                    em_v    = 1'b1;
                    em      = mk_res(K_EXEC, r_sec, r_side, r_ok, r_id, r_price, r_aq,
                                     r_ts, '0);
                    n_after = S_DONE;
                    n_state = S_STORE;
                end else begin
                    n_state = S_CROSS;
                end
            end
            S_REMAIN: begin
                n_after = (!r_ok || (r_aq > 0)) ? S_OWN : S_DONE;
                n_state = S_STORE;
            end
            S_OWN: begin
                if (own_cnt >= CW'(N)) begin
                    em_v    = 1'b1;
                    em      = mk_res(K_REJECT, r_sec, r_side, 1'b0, r_id,
                                     r_ok ? r_mp : r_price, r_aq, r_ts, '0);
                    n_state = S_DONE;
                end else begin
                    if (r_ok) begin
                        // Market remainder rests as a limit order at the market price.
                        em_v    = 1'b1;
                        em      = mk_res(K_ECHO, r_sec, r_side, 1'b0, r_id, r_mp, r_aq,
                                         r_ts, '0);
                        n_price = r_mp;
                        n_ok    = 1'b0;
                    end
                    n_bside = r_side;
                    n_n     = own_cnt;
                    n_after = S_INS;
                    n_state = S_LOAD;
                end
            end
            S_INS: begin
                c_cmd.op      = OP_WRITE;
                c_idx         = r_n[SW-1:0];
                c_wdata.price = r_price;
                c_wdata.qty   = r_aq;
                c_wdata.ts    = r_ts;
                c_wdata.id    = r_id;
                n_i     = r_n[SW-1:0];
                n_n     = r_n + CW'(1);
                n_ret   = S_STORE;
                n_after = S_DONE;
                n_state = S_SUP;
            end
            S_STORE: begin
                bk_we    = 1'b1;
                c_cmd.op = OP_SHIFT;
                if (r_k == CW'(N - 1)) begin
                    n_k = '0;
                    if (r_bside) begin
                        n_scnt = r_n;
                    end else begin
                        n_bcnt = r_n;
                    end
                    n_state = r_after;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_DONE: begin
                meta_we = 1'b1;
                flush   = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    lob_row #(
        .ORDERS_PER_SIDE (ORDERS_PER_SIDE)
    ) u_row (
        .i_clk     (i_clk),
        .i_cmd     (c_cmd),
        .i_idx     (c_idx),
        .i_cnt     (r_n),
        .i_wdata   (c_wdata),
        .i_shin    (r_bk_rd),
        .i_cid     (r_cid),
        .i_ridx    (c_ridx),
        .o_top     (row_top),
        .o_rdata   (row_rdata),
        .o_stat    (row_stat),
        .o_hit_idx (row_hit_idx)
    );

    // Book memory: loads read slot by slot, stores write the head of the chain.
    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            r_bk_mem[{r_bside, r_sec[SECW-1:0], c_slot}] <= row_top;
        end
        r_bk_rd <= r_bk_mem[{r_bside, r_sec[SECW-1:0], c_slot}];
    end

    // Security record memory.
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[r_sec[SECW-1:0]] <= {r_bcnt, r_scnt, r_mp};
        end
        r_meta_rd <= r_meta_mem[i_security[SECW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_n      <= '0;
            r_mvalid <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
            if (meta_we) begin
                r_mvalid[r_sec[SECW-1:0]] <= 1'b1;
            end
            r_ov <= 1'b0;
            if (em_v) begin
                r_pv <= 1'b1;
                r_ov <= r_pv;
            end else if (flush) begin
                r_pv <= 1'b0;
                r_ov <= r_pv;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_after <= n_after;
        r_i     <= n_i;
        r_bside <= n_bside;
        r_na    <= n_na;
        r_nm    <= n_nm;
        r_bcnt  <= n_bcnt;
        r_scnt  <= n_scnt;
        r_mp    <= n_mp;
        if (acc) begin
            r_func  <= i_func;
            r_sec   <= i_security;
            r_side  <= i_side;
            r_ok    <= i_order_kind;
            r_id    <= i_order_id;
            r_price <= i_price;
            r_aq    <= signed'({1'b0, i_quantity});
            r_ts    <= i_timestamp;
            r_cid   <= i_cancel_id;
        end else begin
            r_ok    <= n_ok;
            r_price <= n_price;
            r_aq    <= n_aq;
        end
        // A report is shown once the next one is known, so the last can be marked.
        if (em_v) begin
            r_pend  <= em;
            r_out   <= r_pend;
            r_olast <= 1'b0;
        end else if (flush) begin
            r_out   <= r_pend;
            r_olast <= 1'b1;
        end
    end

    assign o_valid          = r_ov;
    assign o_kind           = r_out.kind;
    assign o_security_res   = r_out.sec;
    assign o_side_res       = r_out.side;
    assign o_order_kind_res = r_out.ok;
    assign o_order_id_res   = r_out.id;
    assign o_price_res      = r_out.price;
    assign o_quantity_res   = r_out.qty;
    assign o_timestamp_res  = r_out.ts;
    assign o_resting_id     = r_out.matched;
    assign o_last           = r_olast;

    // The working book never holds more orders than a side allows.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(N))
        else $error("working book count above capacity");

    // The final report of an item is never followed at once by another.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("report directly after the final report");

    // Every item that reaches its end has a staged report to close it.
    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_pv)
        else $error("item finished without a staged report");

endmodule
`default_nettype wire

FILE: verif/limit_order_book_matcher_test.sv
// Self-checking testbench for the limit order book matcher: a price-time priority
// predictor in a small scoreboard class checks every report the block gives.
// Depends on lob_pkg and the limit_order_book_matcher RTL.
`default_nettype none
module limit_order_book_matcher_test;
    import lob_pkg::*;

    localparam int NSEC  = 4;
    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // A resting order with the wide quantity the arithmetic needs.
    typedef struct {
        logic [31:0] price;
        longint      qty;
        logic [31:0] ts;
        logic [31:0] id;
    } book_entry_t;

    // One expected report and its final-report flag.
    typedef struct {
        t_result rep;
        logic    last;
    } report_t;

    // Book state, predicted reports and the comparison against the block.
    class book_scoreboard;
        book_entry_t books [2][NSEC][DEPTH];
        int          counts [2][NSEC];
        logic [31:0] mkt [NSEC];
        report_t     pending [$];
        report_t     step_reps [$];
        int          errors;

        function new();
            errors = 0;
            for (int s = 0; s < NSEC; s++) begin
                mkt[s] = s;
                counts[0][s] = 0;
                counts[1][s] = 0;
            end
        endfunction

        function bit ranks_ahead(bit sd, book_entry_t a, book_entry_t b);
            if (a.price == b.price) return a.ts < b.ts;
            return sd ? (a.price < b.price) : (a.price > b.price);
        endfunction

        function void swap_entries(bit sd, int sec, int i, int j);
            book_entry_t t;
            t = books[sd][sec][i];
            books[sd][sec][i] = books[sd][sec][j];
            books[sd][sec][j] = t;
        endfunction

        function void sift_up(bit sd, int sec, int i);
            int p;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!ranks_ahead(sd, books[sd][sec][i], books[sd][sec][p])) break;
                swap_entries(sd, sec, i, p);
                i = p;
            end
        endfunction

        function void sift_down(bit sd, int sec, int n, int i);
            int l, r, b;
            forever begin
                l = 2 * i + 1;
                r = l + 1;
                b = i;
                if (l < n && ranks_ahead(sd, books[sd][sec][l], books[sd][sec][b])) b = l;
                if (r < n && ranks_ahead(sd, books[sd][sec][r], books[sd][sec][b])) b = r;
                if (b == i) break;
                swap_entries(sd, sec, i, b);
                i = b;
            end
        endfunction

        function void remove_at(bit sd, int sec, int i);
            int n;
            if (counts[sd][sec] == 0 || i >= counts[sd][sec]) return;
            n = counts[sd][sec] - 1;
            counts[sd][sec] = n;
            if (i >= n) return;
            books[sd][sec][i] = books[sd][sec][n];
            if (i > 0 && ranks_ahead(sd, books[sd][sec][i], books[sd][sec][(i - 1) / 2]))
                sift_up(sd, sec, i);
            else
                sift_down(sd, sec, n, i);
        endfunction

        function void add_report(logic [2:0] kind, int sec, bit sd, bit ok, logic [31:0] id,
                                 logic [31:0] price, longint qty, logic [31:0] ts,
                                 logic [31:0] matched);
            report_t e;
            e.rep = mk_res(kind, sec[7:0], sd, ok, id, price, qty[31:0], ts, matched);
            e.last = 1'b0;
            step_reps.push_back(e);
        endfunction

        // Works out the reports of one accepted command transfer.
        function void note_command(logic [1:0] func, logic [7:0] sec, bit sd, bit ok,
                                   logic [31:0] id, logic [31:0] price, logic [30:0] qty,
                                   logic [31:0] ts, logic [31:0] cid);
            longint aq, rq, na, nm;
            bit     opp, done, finished;
            book_entry_t top;
            step_reps.delete();
            if (sec >= NSEC || func == F_NONE) return;
            aq = qty;
            if (func == F_SETPRICE) begin
                mkt[sec] = price;
                add_report(K_MPRICE, sec, 0, 0, 0, price, 0, 0, 0);
            end else if (func == F_CANCEL) begin
                done = 0;
                for (int s = 0; s < 2 && !done; s++)
                    for (int i = 0; i < counts[s][sec] && !done; i++)
                        if (books[s][sec][i].id == cid) begin
                            remove_at(s, sec, i);
                            done = 1;
                        end
                add_report(K_CANCEL, sec, 0, 0, cid, 0, 0, 0, 0);
            end else begin
                opp = !sd;
                finished = 0;
                add_report(K_ECHO, sec, sd, ok, id, price, aq, ts, 0);
                while (counts[opp][sec] > 0 && (ok || (sd == 0 ?
                       price >= books[opp][sec][0].price : price <= books[opp][sec][0].price)))
                begin
                    top = books[opp][sec][0];
                    rq = top.qty;
                    na = aq - rq;
                    nm = rq - aq;
                    add_report(K_TRADE, sec, sd, ok, id, price, aq, ts, top.id);
                    if (mkt[sec] != top.price) begin
                        mkt[sec] = top.price;
                        add_report(K_MPRICE, sec, 0, 0, 0, top.price, 0, 0, 0);
                    end
                    aq = na;
                    books[opp][sec][0].qty = nm;
                    if (nm <= 0) begin
                        add_report(K_EXEC, sec, opp, 0, top.id, top.price, nm, top.ts, 0);
                        remove_at(opp, sec, 0);
                        if (na <= 0) begin
                            add_report(K_EXEC, sec, sd, ok, id, price, na, ts, 0);
                            finished = 1;
                            break;
                        end
                    end else begin
                        add_report(K_EXEC, sec, sd, ok, id, price, na, ts, 0);
                        finished = 1;
                        break;
                    end
                end
                if (!finished && (!ok || aq > 0)) begin
                    if (ok) begin
                        price = mkt[sec];
                        ok = 0;
                        if (counts[sd][sec] < DEPTH)
                            add_report(K_ECHO, sec, sd, 0, id, price, aq, ts, 0);
                    end
                    if (counts[sd][sec] >= DEPTH) begin
                        add_report(K_REJECT, sec, sd, 0, id, price, aq, ts, 0);
                    end else begin
                        books[sd][sec][counts[sd][sec]] = '{price, aq, ts, id};
                        counts[sd][sec]++;
                        sift_up(sd, sec, counts[sd][sec] - 1);
                    end
                end
            end
            step_reps[step_reps.size() - 1].last = 1'b1;
            foreach (step_reps[i]) pending.push_back(step_reps[i]);
        endfunction

        // Compares one report against the oldest expectation.
        function void check_report(t_result got, logic got_last);
            report_t e;
            if (pending.size() == 0) begin
                $error("unexpected report, kind %0d id %0d", got.kind, got.id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.rep.kind) begin
                $error("kind: expected %0d, got %0d", e.rep.kind, got.kind); errors++;
            end
            if (got.sec !== e.rep.sec) begin
                $error("security_res: expected %0d, got %0d", e.rep.sec, got.sec); errors++;
            end
            if (got.side !== e.rep.side) begin
                $error("side_res: expected %0d, got %0d", e.rep.side, got.side); errors++;
            end
            if (got.ok !== e.rep.ok) begin
                $error("order_kind_res: expected %0d, got %0d", e.rep.ok, got.ok); errors++;
            end
            if (got.id !== e.rep.id) begin
                $error("order_id_res: expected %0d, got %0d", e.rep.id, got.id); errors++;
            end
            if (got.price !== e.rep.price) begin
                $error("price_res: expected %0d, got %0d", e.rep.price, got.price); errors++;
            end
            if (got.qty !== e.rep.qty) begin
                $error("quantity_res: expected %0d, got %0d", e.rep.qty, got.qty); errors++;
            end
            if (got.ts !== e.rep.ts) begin
                $error("timestamp_res: expected %0d, got %0d", e.rep.ts, got.ts); errors++;
            end
            if (got.matched !== e.rep.matched) begin
                $error("resting_id: expected %0d, got %0d", e.rep.matched, got.matched);
                errors++;
            end
            if (got_last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, got_last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_func = '0;
    logic [7:0]  i_security = '0;
    logic        i_side = 1'b0;
    logic        i_order_kind = 1'b0;
    logic [31:0] i_order_id = '0;
    logic [31:0] i_price = '0;
    logic [30:0] i_quantity = '0;
    logic [31:0] i_timestamp = '0;
    logic [31:0] i_cancel_id = '0;
    logic        busy, o_valid, o_side_res, o_order_kind_res, o_last;
    logic [2:0]  o_kind;
    logic [7:0]  o_security_res;
    logic [31:0] o_order_id_res, o_price_res, o_timestamp_res, o_resting_id;
    logic signed [31:0] o_quantity_res;

    book_scoreboard board = new();
    int idle_pct = 0;
    int idle_cycles = 0;
    logic [31:0] next_id = 32'd100;
    logic [31:0] next_ts = 32'd1000;

    limit_order_book_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_func(i_func),
        .i_security(i_security), .i_side(i_side), .i_order_kind(i_order_kind),
        .i_order_id(i_order_id), .i_price(i_price), .i_quantity(i_quantity),
        .i_timestamp(i_timestamp), .i_cancel_id(i_cancel_id), .busy(busy),
        .o_valid(o_valid), .o_kind(o_kind), .o_security_res(o_security_res),
        .o_side_res(o_side_res), .o_order_kind_res(o_order_kind_res),
        .o_order_id_res(o_order_id_res), .o_price_res(o_price_res),
        .o_quantity_res(o_quantity_res), .o_timestamp_res(o_timestamp_res),
        .o_resting_id(o_resting_id), .o_last(o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Notes command transfers, checks report transfers and runs the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_command(i_func, i_security, i_side, i_order_kind, i_order_id,
                                   i_price, i_quantity, i_timestamp, i_cancel_id);
            end
            if (o_valid) begin
                board.check_report({o_kind, o_security_res, o_side_res, o_order_kind_res,
                                    o_order_id_res, o_price_res, o_quantity_res,
                                    o_timestamp_res, o_resting_id}, o_last);
            end
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Drives one command and holds it until the transfer, then maybe idles.
    task automatic send_command(logic [1:0] func, logic [7:0] sec, bit sd, bit ok,
                                logic [31:0] id, logic [31:0] price, logic [30:0] qty,
                                logic [31:0] ts, logic [31:0] cid);
        int gap;
        start        <= 1'b1;
        i_func       <= func;
        i_security   <= sec;
        i_side       <= sd;
        i_order_kind <= ok;
        i_order_id   <= id;
        i_price      <= price;
        i_quantity   <= qty;
        i_timestamp  <= ts;
        i_cancel_id  <= cid;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // New order with a fresh id and a rising timestamp.
    task automatic place_order(int sec, bit sd, bit ok, logic [31:0] price, logic [30:0] qty);
        next_id++;
        next_ts++;
        send_command(F_NEW, sec, sd, ok, next_id, price, qty, next_ts, 0);
    endtask

    // Lowers start and waits until every predicted report has come.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic random_command();
        int r;
        logic [7:0]  sec;
        logic [31:0] price, cid;
        logic [30:0] qty;
        r   = $urandom_range(99);
        sec = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(NSEC - 1));
        price = ($urandom_range(9) == 0) ? $urandom : $urandom_range(108, 92);
        qty   = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40));
        cid   = ($urandom_range(4) == 0) ? $urandom : next_id - $urandom_range(20);
        next_id++;
        next_ts = next_ts + $urandom_range(2);
        if (r < 10)
            send_command(F_SETPRICE, sec, $urandom, $urandom, $urandom, price, qty,
                         $urandom, $urandom);
        else if (r < 30)
            send_command(F_CANCEL, sec, $urandom, $urandom, $urandom, $urandom, qty,
                         $urandom, cid);
        else if (r < 34)
            send_command(F_NONE, sec, $urandom, $urandom, $urandom, price, qty,
                         $urandom, cid);
        else
            send_command(F_NEW, sec, $urandom, $urandom_range(3) == 0, next_id, price, qty,
                         ($urandom_range(14) == 0) ? $urandom : next_ts, $urandom);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, every function and the corner cases.
        send_command(F_SETPRICE, 0, 1, 1, '1, 32'hFFFF_FFFF, '1, '1, '1);
        send_command(F_SETPRICE, 0, 0, 0, 0, 100, 0, 0, 0);
        send_command(F_NONE, 1, 1, 1, '1, '1, '1, '1, '1);
        send_command(F_NEW, 8'd255, 1, 0, 7, 100, 5, 9, 0);
        send_command(F_NEW, NSEC, 0, 0, 7, 100, 5, 9, 0);
        place_order(1, 0, 1, 50, 10);               // market order onto an empty book
        place_order(1, 1, 0, 120, 0);               // zero quantity rests
        place_order(1, 1, 0, 110, 6);
        place_order(1, 1, 0, 110, 4);
        place_order(1, 0, 0, 115, 31'h7FFF_FFFF);   // sweeps two orders at one price, remainder rests
        place_order(1, 1, 1, 0, 20);                // market sell against the buy side
        send_command(F_CANCEL, 1, 0, 0, 0, 0, 0, 0, next_id);
        send_command(F_CANCEL, 1, 0, 0, 0, 0, 0, 0, 32'hDEAD_BEEF);   // cancel miss
        for (int i = 0; i < DEPTH; i++) place_order(2, 0, 0, 10 + i, 3);
        place_order(2, 0, 0, 5, 1);                 // full book, limit rejected
        place_order(2, 0, 1, 0, 2);                 // market remainder into a full book
        place_order(2, 1, 0, 0, 2);                 // sell crossing the best bid
        drain();

        // Random part in phases of sender idling, each ending with a full drain.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 55 : (ph == 3 ? 33 : 0);
            for (int k = 0; k < 22; k++) random_command();
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: limit_order_book_matcher.f
rtl/lob_pkg.sv
rtl/lob_cell.sv
rtl/lob_row.sv
rtl/limit_order_book_matcher.sv
verif/limit_order_book_matcher_test.sv
